>>> rtl/srtn_pkg.sv
// Shared constants and types for the shortest-remaining-time tick scheduler.
package srtn_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_IDLE     = 2'd2;
    localparam logic [1:0] ST_RAN      = 2'd3;

    typedef struct packed {
        logic       load;      // capture input item
        logic       commit;    // update slot state from scan result
        logic       scan_clr;  // start a new scan
        logic       scan_step; // compare one slot
    } srtn_cmd_t;

    typedef struct packed {
        logic       scan_done;
    } srtn_stat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  run_id;
        logic [31:0] tick_time;
        logic        first_run;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [31:0] response;
    } srtn_result_t;

endpackage

>>> rtl/srtn_ctrl.sv
// Controller state machine: load item, scan slots, commit, present result.
module srtn_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  srtn_pkg::srtn_stat_t stat,
    output srtn_pkg::srtn_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold the update until the result register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_SCAN)
        else $error("load did not start a scan");
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise result valid");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("ready while busy");
`endif

endmodule

>>> rtl/srtn_datapath.sv
// Slot table, serial shortest-job scan, tick counter and result register.
module srtn_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_req_type,
    input  logic [7:0]             in_job_id,
    input  logic [15:0]            in_burst_len,
    input  srtn_pkg::srtn_cmd_t    cmd,
    output srtn_pkg::srtn_stat_t   stat,
    output srtn_pkg::srtn_result_t result
);

    localparam int SW = srtn_pkg::SLOT_W;

    logic [srtn_pkg::SLOTS-1:0] valid_reg, valid_next;
    logic [srtn_pkg::SLOTS-1:0] started_reg, started_next;
    logic [7:0]  job_reg     [srtn_pkg::SLOTS];
    logic [15:0] rem_reg     [srtn_pkg::SLOTS];
    logic [15:0] burst_reg   [srtn_pkg::SLOTS];
    logic [31:0] arr_reg     [srtn_pkg::SLOTS];
    logic [31:0] first_reg   [srtn_pkg::SLOTS];
    logic [31:0] now_reg, now_next;

    logic        req_reg;
    logic [7:0]  id_reg;
    logic [15:0] blen_reg;

    // scan state
    logic [SW:0]   idx_reg;
    logic          best_ok_reg;
    logic [SW-1:0] best_reg;
    logic          free_ok_reg;
    logic [SW-1:0] free_reg;

    srtn_pkg::srtn_result_t res_reg, res_next;

    logic [SW-1:0] cur;
    logic          better;
    assign cur = idx_reg[SW-1:0];
    assign better = valid_reg[cur] && (!best_ok_reg ||
                    rem_reg[cur] < rem_reg[best_reg] ||
                    (rem_reg[cur] == rem_reg[best_reg] &&
                     arr_reg[cur] < arr_reg[best_reg]));

    assign stat.scan_done = (idx_reg == (SW+1)'(srtn_pkg::SLOTS - 1)) ||
                            (idx_reg[SW] == 1'b1);
    assign result = res_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= in_req_type;
            id_reg   <= in_job_id;
            blen_reg <= in_burst_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            best_ok_reg <= 1'b0;
            free_ok_reg <= 1'b0;
        end else if (cmd.scan_clr) begin
            idx_reg     <= '0;
            best_ok_reg <= 1'b0;
            free_ok_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + (SW+1)'(1);
            if (better) begin
                best_ok_reg <= 1'b1;
                best_reg    <= cur;
            end
            // keep the lowest free slot
            if (!valid_reg[cur] && !free_ok_reg) begin
                free_ok_reg <= 1'b1;
                free_reg    <= cur;
            end
        end
    end

    logic [31:0] tat;
    assign tat = now_reg - arr_reg[best_reg] + 32'd1;

    always_comb begin
        valid_next   = valid_reg;
        started_next = started_reg;
        now_next     = now_reg;
        res_next     = res_reg;
        if (cmd.commit) begin
            res_next           = '0;
            res_next.tick_time = now_reg;
            if (req_reg == srtn_pkg::REQ_ARRIVAL) begin
                if (!free_ok_reg) begin
                    res_next.status = srtn_pkg::ST_FULL;
                end else begin
                    res_next.status        = srtn_pkg::ST_ACCEPTED;
                    valid_next[free_reg]   = 1'b1;
                    started_next[free_reg] = 1'b0;
                end
            end else begin
                now_next = now_reg + 32'd1;
                if (!best_ok_reg) begin
                    res_next.status = srtn_pkg::ST_IDLE;
                end else begin
                    res_next.status = srtn_pkg::ST_RAN;
                    res_next.run_id = job_reg[best_reg];
                    if (!started_reg[best_reg]) begin
                        started_next[best_reg] = 1'b1;
                        res_next.first_run     = 1'b1;
                    end
                    if (rem_reg[best_reg] <= 16'd1) begin
                        res_next.finished   = 1'b1;
                        res_next.turnaround = tat;
                        res_next.waiting    = tat - {16'd0, burst_reg[best_reg]};
                        res_next.response   = (started_reg[best_reg] ?
                                               first_reg[best_reg] : now_reg)
                                              - arr_reg[best_reg];
                        valid_next[best_reg]   = 1'b0;
                        started_next[best_reg] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            started_reg <= '0;
            now_reg     <= '0;
        end else begin
            valid_reg   <= valid_next;
            started_reg <= started_next;
            now_reg     <= now_next;
        end
        res_reg <= res_next;
    end

    // slot payload writes
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (req_reg == srtn_pkg::REQ_ARRIVAL) begin
                if (free_ok_reg) begin
                    job_reg[free_reg]   <= id_reg;
                    burst_reg[free_reg] <= blen_reg;
                    rem_reg[free_reg]   <= blen_reg;
                    arr_reg[free_reg]   <= now_reg;
                end
            end else if (best_ok_reg) begin
                if (!started_reg[best_reg]) begin
                    first_reg[best_reg] <= now_reg;
                end
                if (rem_reg[best_reg] <= 16'd1) begin
                    rem_reg[best_reg] <= 16'd0;
                end else begin
                    rem_reg[best_reg] <= rem_reg[best_reg] - 16'd1;
                end
            end
        end
    end

`ifndef SYNTH
    a_started_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (started_reg & ~valid_reg) == '0)
        else $error("started bit on a free slot");
    a_tick_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && req_reg == srtn_pkg::REQ_TICK) |=> now_reg == $past(now_reg) + 32'd1)
        else $error("tick did not advance counter");
    a_arr_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && req_reg == srtn_pkg::REQ_ARRIVAL) |=> now_reg == $past(now_reg))
        else $error("arrival moved tick counter");
`endif

endmodule

>>> rtl/srtn_tick_scheduler.sv
// Top level of the shortest-remaining-time-next tick scheduler.
// Each input item is a job arrival or one time tick; each gives exactly one result item.
// An item is handled in steps: capture it, a serial scan of the slots that finds the
// lowest free slot and the shortest remaining job, and an update of the slot table that
// also loads the result register. A waiting result does not block the capture of the
// next item; only the final update step waits while the previous result is still
// unaccepted. No clearing pass follows reset.
module srtn_tick_scheduler (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,  // job_id[7:0], burst_len[23:8]
    input  logic         s_tuser,  // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,  // run_id[7:0], tick_time[39:8], first_run[40],
                                   // finished[41], turnaround[73:42], waiting[105:74],
                                   // response[137:106], zero[143:138]
    output logic [1:0]   m_tuser   // status
);

    srtn_pkg::srtn_cmd_t    cmd;
    srtn_pkg::srtn_stat_t   stat;
    srtn_pkg::srtn_result_t res;

    srtn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srtn_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_req_type  (s_tuser),
        .in_job_id    (s_tdata[7:0]),
        .in_burst_len (s_tdata[23:8]),
        .cmd          (cmd),
        .stat         (stat),
        .result       (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {6'd0, res.response, res.waiting, res.turnaround,
                      res.finished, res.first_run, res.tick_time, res.run_id};

endmodule
